/* rtl/one_wire_master_sequencer_assert.svh */
// ---------------------------------------------------------------------------
// One-wire master sequencer assertion macros
// Clocked on clk, disabled during rst; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ONE_WIRE_MASTER_SEQUENCER_ASSERT_SVH
`define ONE_WIRE_MASTER_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

`define OWM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("one-wire sequencer check failed");

`define OWM_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("one-wire sequencer check failed");

`else

`define OWM_ASSERT_IMPL(label, ante, cons)

`define OWM_ASSERT_NEVER(label, expr)

`endif

`endif

/* rtl/owm_pkg.sv */
// ---------------------------------------------------------------------------
// One-wire master sequencer package
// Command codes, register indexes, phase encoding and shared item types.
// ---------------------------------------------------------------------------
package owm_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_COUNT = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AFTER_RESET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DOWN   = 3'd4;

  localparam logic [CFG_W-1:0] DEF_RESET_LOW   = 12'd480;
  localparam logic [CFG_W-1:0] DEF_SHORT       = 12'd10;
  localparam logic [CFG_W-1:0] DEF_LONG        = 12'd60;
  localparam logic [CFG_W-1:0] DEF_AFTER_RESET = 12'd480;
  localparam logic [CFG_W-1:0] DEF_HOLD_DOWN   = 12'd2;

  localparam int BITS_PER_BYTE = 8;
  localparam logic [2:0] BIT_LAST = 3'(BITS_PER_BYTE - 1);

  localparam logic [1:0] STATUS_PRESENCE = 2'd0;
  localparam logic [1:0] STATUS_NONE     = 2'd1;
  localparam logic [1:0] STATUS_BUS_LOW  = 2'd2;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [9:0] {
    PH_IDLE      = 10'b00_0000_0001,
    PH_RST_LOW   = 10'b00_0000_0010,
    PH_RST_WAIT  = 10'b00_0000_0100,
    PH_RST_RECOV = 10'b00_0000_1000,
    PH_WR_LOW    = 10'b00_0001_0000,
    PH_WR_HIGH   = 10'b00_0010_0000,
    PH_RD_HOLD   = 10'b00_0100_0000,
    PH_RD_DELAY  = 10'b00_1000_0000,
    PH_RD_REST   = 10'b01_0000_0000,
    PH_RD_FINAL  = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic       is_reset;
    logic       is_write;
    logic       is_read;
    logic [7:0] tx_byte;
    logic       line_level;
  } op_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] rx_byte;
    logic       done;
    logic       busy;
    logic       drive_low;
  } result_t;

endpackage

/* rtl/owm_front.sv */
// ---------------------------------------------------------------------------
// One-wire master front end
// Unpacks an input item and classifies its command into operation flags.
// ---------------------------------------------------------------------------
module owm_front (
  input  logic [15:0]   tdata,
  input  logic [1:0]    tuser,
  output owm_pkg::op_t  op
);

  owm_pkg::cmd_t cmd;

  assign cmd = owm_pkg::cmd_t'(tuser);

  always_comb begin
    op            = '0;
    op.tx_byte    = tdata[7:0];
    op.line_level = tdata[8];
    unique case (cmd)
      owm_pkg::CMD_RESET: op.is_reset = 1'b1;
      owm_pkg::CMD_WRITE: op.is_write = 1'b1;
      owm_pkg::CMD_READ:  op.is_read  = 1'b1;
      default: ;
    endcase
  end

endmodule

/* rtl/owm_queue.sv */
// ---------------------------------------------------------------------------
// One-wire master item queue
// Two-entry FIFO between the front end and the sequencer.
// ---------------------------------------------------------------------------
module owm_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  owm_pkg::op_t push_op,
  output logic         in_ready,
  input  logic         pop,
  output owm_pkg::op_t pop_op,
  output logic         out_valid
);

  localparam int PTR_W = $clog2(owm_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(owm_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(owm_pkg::QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(owm_pkg::QUEUE_DEPTH - 1);

  owm_pkg::op_t     entries [owm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign in_ready  = (count != FULL);
  assign out_valid = (count != '0);
  assign do_push   = push && in_ready;
  assign do_pop    = pop && out_valid;
  assign pop_op    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/owm_back.sv */
// ---------------------------------------------------------------------------
// One-wire master back end
// Timing registers, slot sequencer and registered result output.
// ---------------------------------------------------------------------------
`include "one_wire_master_sequencer_assert.svh"

module owm_back #(
  parameter int TIMER_WIDTH = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic [owm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [owm_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                 op_valid,
  input  owm_pkg::op_t                         op,
  output logic                                 op_pop,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output owm_pkg::result_t                     result
);

  localparam int WIDE = (TIMER_WIDTH > owm_pkg::CFG_W) ? TIMER_WIDTH : owm_pkg::CFG_W;
  localparam logic [WIDE-1:0] TMAX = WIDE'((64'd1 << TIMER_WIDTH) - 64'd1);

  logic [owm_pkg::CFG_W-1:0] cfg_regs [owm_pkg::CFG_COUNT];

  owm_pkg::phase_t        phase, phase_next;
  logic [TIMER_WIDTH-1:0] tick_count, tick_count_next;
  logic [2:0]             bit_index, bit_index_next;
  logic [7:0]             shift_byte, shift_byte_next;
  logic [1:0]             last_status, last_status_next;
  logic [7:0]             rx_last, rx_last_next;
  logic                   done_next;
  logic                   drive_next;
  owm_pkg::phase_t        ph_cur;

  function automatic logic [TIMER_WIDTH-1:0] dur(input logic [owm_pkg::CFG_W-1:0] v);
    logic [WIDE-1:0] vw;
    vw = WIDE'(v);
    if (vw > TMAX) vw = TMAX;
    if (vw == '0) vw = WIDE'(1);
    return vw[TIMER_WIDTH-1:0];
  endfunction

  assign op_pop = op_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs[owm_pkg::CFG_RESET_LOW]   <= owm_pkg::DEF_RESET_LOW;
      cfg_regs[owm_pkg::CFG_SHORT]       <= owm_pkg::DEF_SHORT;
      cfg_regs[owm_pkg::CFG_LONG]        <= owm_pkg::DEF_LONG;
      cfg_regs[owm_pkg::CFG_AFTER_RESET] <= owm_pkg::DEF_AFTER_RESET;
      cfg_regs[owm_pkg::CFG_HOLD_DOWN]   <= owm_pkg::DEF_HOLD_DOWN;
    end else if (cfg_valid && (cfg_index < owm_pkg::CFG_IDX_W'(owm_pkg::CFG_COUNT))) begin
      cfg_regs[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    phase_next       = phase;
    tick_count_next  = tick_count;
    bit_index_next   = bit_index;
    shift_byte_next  = shift_byte;
    last_status_next = last_status;
    rx_last_next     = rx_last;
    done_next        = 1'b0;
    drive_next       = 1'b0;

    if (phase == owm_pkg::PH_IDLE) begin
      if (op.is_reset) begin
        if (!op.line_level) begin
          last_status_next = owm_pkg::STATUS_BUS_LOW;
          done_next        = 1'b1;
        end else begin
          phase_next      = owm_pkg::PH_RST_LOW;
          tick_count_next = dur(cfg_regs[owm_pkg::CFG_RESET_LOW]);
        end
      end else if (op.is_write) begin
        shift_byte_next = op.tx_byte;
        bit_index_next  = '0;
        phase_next      = owm_pkg::PH_WR_LOW;
        tick_count_next = op.tx_byte[0] ? dur(cfg_regs[owm_pkg::CFG_SHORT])
                                        : dur(cfg_regs[owm_pkg::CFG_LONG]);
      end else if (op.is_read) begin
        shift_byte_next = '0;
        bit_index_next  = '0;
        phase_next      = owm_pkg::PH_RD_HOLD;
        tick_count_next = dur(cfg_regs[owm_pkg::CFG_HOLD_DOWN]);
      end
    end

    ph_cur = phase_next;
    if (ph_cur != owm_pkg::PH_IDLE) begin
      drive_next = (ph_cur == owm_pkg::PH_RST_LOW) || (ph_cur == owm_pkg::PH_WR_LOW) ||
                   (ph_cur == owm_pkg::PH_RD_HOLD);
      if (tick_count_next != '0) tick_count_next = tick_count_next - 1'b1;
      if (tick_count_next == '0) begin
        unique case (ph_cur)
          owm_pkg::PH_RST_LOW: begin
            phase_next      = owm_pkg::PH_RST_WAIT;
            tick_count_next = dur(cfg_regs[owm_pkg::CFG_LONG]);
          end
          owm_pkg::PH_RST_WAIT: begin
            last_status_next = op.line_level ? owm_pkg::STATUS_NONE
                                             : owm_pkg::STATUS_PRESENCE;
            phase_next       = owm_pkg::PH_RST_RECOV;
            tick_count_next  = dur(cfg_regs[owm_pkg::CFG_AFTER_RESET]);
          end
          owm_pkg::PH_WR_LOW: begin
            phase_next      = owm_pkg::PH_WR_HIGH;
            tick_count_next = shift_byte_next[0] ? dur(cfg_regs[owm_pkg::CFG_LONG])
                                                 : dur(cfg_regs[owm_pkg::CFG_SHORT]);
          end
          owm_pkg::PH_WR_HIGH: begin
            shift_byte_next = {1'b0, shift_byte_next[7:1]};
            if (bit_index_next == owm_pkg::BIT_LAST) begin
              phase_next      = owm_pkg::PH_IDLE;
              tick_count_next = '0;
              done_next       = 1'b1;
            end else begin
              bit_index_next  = bit_index_next + 1'b1;
              phase_next      = owm_pkg::PH_WR_LOW;
              tick_count_next = shift_byte_next[0] ? dur(cfg_regs[owm_pkg::CFG_SHORT])
                                                   : dur(cfg_regs[owm_pkg::CFG_LONG]);
            end
          end
          owm_pkg::PH_RD_HOLD: begin
            phase_next      = owm_pkg::PH_RD_DELAY;
            tick_count_next = dur(cfg_regs[owm_pkg::CFG_SHORT]);
          end
          owm_pkg::PH_RD_DELAY: begin
            shift_byte_next = {op.line_level, shift_byte_next[7:1]};
            phase_next      = owm_pkg::PH_RD_REST;
            tick_count_next = dur(cfg_regs[owm_pkg::CFG_LONG]);
          end
          owm_pkg::PH_RD_REST: begin
            if (bit_index_next == owm_pkg::BIT_LAST) begin
              phase_next = owm_pkg::PH_RD_FINAL;
              tick_count_next = dur(cfg_regs[owm_pkg::CFG_LONG]);
            end else begin
              bit_index_next  = bit_index_next + 1'b1;
              phase_next      = owm_pkg::PH_RD_HOLD;
              tick_count_next = dur(cfg_regs[owm_pkg::CFG_HOLD_DOWN]);
            end
          end
          owm_pkg::PH_RD_FINAL: begin
            rx_last_next    = shift_byte_next;
            phase_next      = owm_pkg::PH_IDLE;
            tick_count_next = '0;
            done_next       = 1'b1;
          end
          default: begin
            phase_next      = owm_pkg::PH_IDLE;
            tick_count_next = '0;
            done_next       = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= owm_pkg::PH_IDLE;
      tick_count  <= '0;
      bit_index   <= '0;
      shift_byte  <= '0;
      last_status <= '0;
      rx_last     <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (op_pop) begin
        phase       <= phase_next;
        tick_count  <= tick_count_next;
        bit_index   <= bit_index_next;
        shift_byte  <= shift_byte_next;
        last_status <= last_status_next;
        rx_last     <= rx_last_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      result.drive_low <= drive_next;
      result.busy      <= (phase_next != owm_pkg::PH_IDLE);
      result.done      <= done_next;
      result.rx_byte   <= rx_last_next;
      result.status    <= last_status_next;
    end
  end

  `OWM_ASSERT_IMPL(a_idle_count_zero, phase == owm_pkg::PH_IDLE, tick_count == '0)
  `OWM_ASSERT_IMPL(a_busy_count_live, phase != owm_pkg::PH_IDLE, tick_count != '0)
  `OWM_ASSERT_IMPL(a_done_not_busy, m_tvalid && result.done, !result.busy)
  `OWM_ASSERT_NEVER(a_drive_on_done, m_tvalid && result.drive_low && result.done)

endmodule

/* rtl/one_wire_master_sequencer.sv */
// Path: an accepted input item is registered in the queue, then the sequencer step
//   registers its result item in the output register.
// Throughput: 1 item per cycle while the result output is not held by a low m_tready.
// Reset: synchronous; clears the queue, sequencer and output valid, and loads
//   the timing registers with their defaults. No clearing pass.
// ---------------------------------------------------------------------------
// One-wire master sequencer
// Tick-driven 1-Wire bus master: reset/presence, byte write and byte read.
// ---------------------------------------------------------------------------
module one_wire_master_sequencer #(
  parameter int TIMER_WIDTH = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [15:0]                   s_tdata,   // tx_byte[7:0], line_level[8], zeros
  input  logic [1:0]                    s_tuser,   // command[1:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [15:0]                   m_tdata,   // drive_low[0], busy_res[1], done_res[2],
                                                   // rx_byte[10:3], status[12:11], zeros
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [owm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [owm_pkg::CFG_W-1:0]     cfg_data
);

  owm_pkg::op_t     front_op;
  owm_pkg::op_t     queue_op;
  logic             queue_valid;
  logic             queue_pop;
  owm_pkg::result_t result;

  assign cfg_ready = 1'b1;

  owm_front u_front (
    .tdata (s_tdata),
    .tuser (s_tuser),
    .op    (front_op)
  );

  owm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid),
    .push_op   (front_op),
    .in_ready  (s_tready),
    .pop       (queue_pop),
    .pop_op    (queue_op),
    .out_valid (queue_valid)
  );

  owm_back #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op_valid  (queue_valid),
    .op        (queue_op),
    .op_pop    (queue_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .result    (result)
  );

  assign m_tdata = {3'b000, result.status, result.rx_byte, result.done, result.busy,
                    result.drive_low};

endmodule

/* bench/one_wire_master_sequencer_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// One-wire master sequencer checker
// Watches the config, input and result channels, predicts each tick's result
// from its own model of the sequencer and compares it with what comes out.
// ---------------------------------------------------------------------------
module one_wire_master_sequencer_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [15:0]                   s_tdata,   // tx_byte[7:0], line_level[8], zeros
  input  logic [1:0]                    s_tuser,   // command[1:0]
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [15:0]                   m_tdata,   // drive_low[0], busy_res[1], done_res[2],
                                                   // rx_byte[10:3], status[12:11], zeros
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [owm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [owm_pkg::CFG_W-1:0]     cfg_data,
  output int                            results_due,
  output int                            mismatches
);

  logic [owm_pkg::CFG_W-1:0] timing [owm_pkg::CFG_COUNT];
  owm_pkg::phase_t           ph;
  logic [owm_pkg::CFG_W-1:0] ticks_left;
  logic [2:0]                bit_no;
  logic [7:0]                shreg;
  logic [1:0]                bus_status;
  logic [7:0]                rx_hold;

  owm_pkg::result_t pending_results [$];

  function automatic void arm(input owm_pkg::phase_t next,
                              input logic [owm_pkg::CFG_W-1:0] ticks);
    ph         = next;
    ticks_left = (ticks == '0) ? owm_pkg::CFG_W'(1) : ticks;
  endfunction

  function automatic void go_idle();
    ph         = owm_pkg::PH_IDLE;
    ticks_left = '0;
  endfunction

  task automatic step_bus_master(input owm_pkg::cmd_t cmd, input logic [7:0] tx,
                                 input logic line, output owm_pkg::result_t r);
    logic done;
    done = 1'b0;
    r    = '0;
    if (ph == owm_pkg::PH_IDLE) begin
      case (cmd)
        owm_pkg::CMD_RESET: begin
          if (!line) begin
            bus_status = owm_pkg::STATUS_BUS_LOW;
            done       = 1'b1;
          end else begin
            arm(owm_pkg::PH_RST_LOW, timing[owm_pkg::CFG_RESET_LOW]);
          end
        end
        owm_pkg::CMD_WRITE: begin
          shreg  = tx;
          bit_no = '0;
          arm(owm_pkg::PH_WR_LOW, shreg[0] ? timing[owm_pkg::CFG_SHORT]
                                           : timing[owm_pkg::CFG_LONG]);
        end
        owm_pkg::CMD_READ: begin
          shreg  = '0;
          bit_no = '0;
          arm(owm_pkg::PH_RD_HOLD, timing[owm_pkg::CFG_HOLD_DOWN]);
        end
        default: ;
      endcase
    end

    if (ph != owm_pkg::PH_IDLE) begin
      r.drive_low = (ph == owm_pkg::PH_RST_LOW) || (ph == owm_pkg::PH_WR_LOW) ||
                    (ph == owm_pkg::PH_RD_HOLD);
      if (ticks_left != '0) ticks_left = ticks_left - 1'b1;
      if (ticks_left == '0) begin
        case (ph)
          owm_pkg::PH_RST_LOW: arm(owm_pkg::PH_RST_WAIT, timing[owm_pkg::CFG_LONG]);
          owm_pkg::PH_RST_WAIT: begin
            bus_status = line ? owm_pkg::STATUS_NONE : owm_pkg::STATUS_PRESENCE;
            arm(owm_pkg::PH_RST_RECOV, timing[owm_pkg::CFG_AFTER_RESET]);
          end
          owm_pkg::PH_WR_LOW: arm(owm_pkg::PH_WR_HIGH, shreg[0] ? timing[owm_pkg::CFG_LONG]
                                                                : timing[owm_pkg::CFG_SHORT]);
          owm_pkg::PH_WR_HIGH: begin
            shreg = shreg >> 1;
            if (bit_no == owm_pkg::BIT_LAST) begin
              go_idle();
              done = 1'b1;
            end else begin
              bit_no = bit_no + 1'b1;
              arm(owm_pkg::PH_WR_LOW, shreg[0] ? timing[owm_pkg::CFG_SHORT]
                                               : timing[owm_pkg::CFG_LONG]);
            end
          end
          owm_pkg::PH_RD_HOLD: arm(owm_pkg::PH_RD_DELAY, timing[owm_pkg::CFG_SHORT]);
          owm_pkg::PH_RD_DELAY: begin
            shreg = {line, shreg[7:1]};
            arm(owm_pkg::PH_RD_REST, timing[owm_pkg::CFG_LONG]);
          end
          owm_pkg::PH_RD_REST: begin
            if (bit_no == owm_pkg::BIT_LAST) begin
              arm(owm_pkg::PH_RD_FINAL, timing[owm_pkg::CFG_LONG]);
            end else begin
              bit_no = bit_no + 1'b1;
              arm(owm_pkg::PH_RD_HOLD, timing[owm_pkg::CFG_HOLD_DOWN]);
            end
          end
          owm_pkg::PH_RD_FINAL: begin
            rx_hold = shreg;
            go_idle();
            done = 1'b1;
          end
          default: begin
            go_idle();
            done = 1'b1;
          end
        endcase
      end
    end

    r.busy    = (ph != owm_pkg::PH_IDLE);
    r.done    = done;
    r.rx_byte = rx_hold;
    r.status  = bus_status;
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    owm_pkg::result_t want;
    owm_pkg::result_t got;
    if (rst) begin
      timing[owm_pkg::CFG_RESET_LOW]   = owm_pkg::DEF_RESET_LOW;
      timing[owm_pkg::CFG_SHORT]       = owm_pkg::DEF_SHORT;
      timing[owm_pkg::CFG_LONG]        = owm_pkg::DEF_LONG;
      timing[owm_pkg::CFG_AFTER_RESET] = owm_pkg::DEF_AFTER_RESET;
      timing[owm_pkg::CFG_HOLD_DOWN]   = owm_pkg::DEF_HOLD_DOWN;
      go_idle();
      bit_no     = '0;
      shreg      = '0;
      bus_status = owm_pkg::STATUS_PRESENCE;
      rx_hold    = '0;
      pending_results.delete();
      results_due <= 0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < owm_pkg::CFG_COUNT) begin
        timing[cfg_index] = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        step_bus_master(owm_pkg::cmd_t'(s_tuser), s_tdata[7:0], s_tdata[8], want);
        pending_results.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got = owm_pkg::result_t'(m_tdata[12:0]);
        if (pending_results.size() == 0) begin
          $error("result item with nothing expected: %h", m_tdata);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          compare_field("drive_low", want.drive_low, got.drive_low);
          compare_field("busy_res", want.busy, got.busy);
          compare_field("done_res", want.done, got.done);
          compare_field("rx_byte", want.rx_byte, got.rx_byte);
          compare_field("status", want.status, got.status);
        end
      end
      results_due <= pending_results.size();
    end
  end

endmodule

/* bench/one_wire_master_sequencer_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// One-wire master sequencer testbench
// Runs bus resets, byte writes and byte reads as tick streams under several
// timing settings, with bursty input and a stalling receiver; the checker
// predicts every result and counts mismatches.
// ---------------------------------------------------------------------------
module one_wire_master_sequencer_tb;

  localparam int LIMIT_CYCLES = 200_000;
  localparam int RANDOM_ITEMS = 370;

  localparam int LINE_LOW  = 0;
  localparam int LINE_HIGH = 1;
  localparam int LINE_RAND = 2;

  localparam int READY_ALWAYS = 0;
  localparam int READY_RANDOM = 1;
  localparam int READY_BURSTY = 2;

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [15:0]                   s_tdata;
  logic [1:0]                    s_tuser;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [15:0]                   m_tdata;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [owm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [owm_pkg::CFG_W-1:0]     cfg_data;
  int                            results_due;
  int                            mismatches;

  int                            cycles = 0;
  int                            burst_left = 0;
  int                            items_sent = 0;
  int                            stall_mode = READY_ALWAYS;
  int                            stall_left = 0;
  logic [owm_pkg::CFG_W-1:0]     tim [owm_pkg::CFG_COUNT];

  one_wire_master_sequencer uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  one_wire_master_sequencer_checker chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .results_due (results_due),
    .mismatches  (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(READY_ALWAYS, READY_BURSTY);
      stall_left <= $urandom_range(50, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      READY_ALWAYS: m_tready <= 1'b1;
      READY_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
      default:      m_tready <= ((stall_left % 9) > 2);
    endcase
  end

  function automatic int dur(input logic [owm_pkg::CFG_W-1:0] v);
    return (v == '0) ? 1 : int'(v);
  endfunction

  function automatic int op_ticks(input owm_pkg::cmd_t c, input logic first_line);
    case (c)
      owm_pkg::CMD_RESET: return first_line ? dur(tim[owm_pkg::CFG_RESET_LOW]) +
                                              dur(tim[owm_pkg::CFG_LONG]) +
                                              dur(tim[owm_pkg::CFG_AFTER_RESET]) : 1;
      owm_pkg::CMD_WRITE: return owm_pkg::BITS_PER_BYTE * (dur(tim[owm_pkg::CFG_SHORT]) +
                                                           dur(tim[owm_pkg::CFG_LONG]));
      owm_pkg::CMD_READ:  return owm_pkg::BITS_PER_BYTE * (dur(tim[owm_pkg::CFG_HOLD_DOWN]) +
                                                           dur(tim[owm_pkg::CFG_SHORT]) +
                                                           dur(tim[owm_pkg::CFG_LONG])) +
                                 dur(tim[owm_pkg::CFG_LONG]);
      default:            return 1;
    endcase
  endfunction

  function automatic logic line_for(input int mode);
    case (mode)
      LINE_LOW:  return 1'b0;
      LINE_HIGH: return 1'b1;
      default:   return 1'($urandom_range(0, 1));
    endcase
  endfunction

  function automatic logic [owm_pkg::CFG_W-1:0] pick_ticks();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return '0;
    if (sel < 3) return owm_pkg::CFG_W'($urandom_range(4, 24));
    return owm_pkg::CFG_W'($urandom_range(1, 3));
  endfunction

  task automatic send_item(input owm_pkg::cmd_t c, input logic [7:0] tx, input logic line);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= c;
    s_tdata  <= {7'd0, line, tx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // command item, ticks until the operation ends, then a few idle ticks
  task automatic run_op(input owm_pkg::cmd_t c, input logic [7:0] tx, input logic first_line,
                        input int line_mode, input bit noisy);
    int            total;
    owm_pkg::cmd_t filler;
    total = op_ticks(c, first_line);
    send_item(c, tx, first_line);
    for (int i = 1; i < total; i++) begin
      filler = (noisy && $urandom_range(0, 3) == 0) ? owm_pkg::cmd_t'($urandom_range(0, 3))
                                                    : owm_pkg::CMD_TICK;
      send_item(filler, 8'($urandom_range(0, 255)), line_for(line_mode));
    end
    repeat ($urandom_range(1, 3)) send_item(owm_pkg::CMD_TICK, 8'($urandom_range(0, 255)),
                                            line_for(LINE_RAND));
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [owm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [owm_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tim[idx] = val;
  endtask

  task automatic load_timing(input logic [owm_pkg::CFG_W-1:0] rst_low,
                             input logic [owm_pkg::CFG_W-1:0] short_t,
                             input logic [owm_pkg::CFG_W-1:0] long_t,
                             input logic [owm_pkg::CFG_W-1:0] recov,
                             input logic [owm_pkg::CFG_W-1:0] hold);
    write_reg(owm_pkg::CFG_RESET_LOW, rst_low);
    write_reg(owm_pkg::CFG_SHORT, short_t);
    write_reg(owm_pkg::CFG_LONG, long_t);
    write_reg(owm_pkg::CFG_AFTER_RESET, recov);
    write_reg(owm_pkg::CFG_HOLD_DOWN, hold);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int            mark;
    int            sel;
    owm_pkg::cmd_t c;
    logic          line;

    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= owm_pkg::CMD_TICK;
    cfg_valid <= 1'b0;
    cfg_index <= owm_pkg::CFG_RESET_LOW;
    cfg_data  <= '0;
    tim[owm_pkg::CFG_RESET_LOW]   = owm_pkg::DEF_RESET_LOW;
    tim[owm_pkg::CFG_SHORT]       = owm_pkg::DEF_SHORT;
    tim[owm_pkg::CFG_LONG]        = owm_pkg::DEF_LONG;
    tim[owm_pkg::CFG_AFTER_RESET] = owm_pkg::DEF_AFTER_RESET;
    tim[owm_pkg::CFG_HOLD_DOWN]   = owm_pkg::DEF_HOLD_DOWN;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // default timing
    run_op(owm_pkg::CMD_TICK, 8'h00, 1'b0, LINE_RAND, 1'b0);
    run_op(owm_pkg::CMD_RESET, 8'hFF, 1'b0, LINE_RAND, 1'b0);
    settle();

    // default short and hold-down times
    write_reg(owm_pkg::CFG_RESET_LOW, 12'd3);
    write_reg(owm_pkg::CFG_LONG, 12'd2);
    write_reg(owm_pkg::CFG_AFTER_RESET, 12'd3);
    cfg_valid <= 1'b0;
    run_op(owm_pkg::CMD_RESET, 8'h00, 1'b1, LINE_LOW, 1'b1);
    run_op(owm_pkg::CMD_WRITE, 8'hA5, 1'b1, LINE_RAND, 1'b1);
    run_op(owm_pkg::CMD_READ, 8'h00, 1'b0, LINE_RAND, 1'b0);
    settle();

    // shortest timing
    load_timing(12'd1, 12'd1, 12'd1, 12'd1, 12'd1);
    run_op(owm_pkg::CMD_RESET, 8'h00, 1'b1, LINE_HIGH, 1'b0);
    run_op(owm_pkg::CMD_WRITE, 8'h00, 1'b0, LINE_RAND, 1'b0);
    run_op(owm_pkg::CMD_WRITE, 8'hFF, 1'b1, LINE_RAND, 1'b1);
    run_op(owm_pkg::CMD_READ, 8'hFF, 1'b1, LINE_LOW, 1'b0);
    run_op(owm_pkg::CMD_READ, 8'h00, 1'b0, LINE_RAND, 1'b1);
    settle();

    // zero counts as one tick
    load_timing(12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
    run_op(owm_pkg::CMD_RESET, 8'h00, 1'b1, LINE_RAND, 1'b1);
    run_op(owm_pkg::CMD_WRITE, 8'h3C, 1'b0, LINE_RAND, 1'b1);
    run_op(owm_pkg::CMD_READ, 8'h00, 1'b1, LINE_RAND, 1'b0);
    run_op(owm_pkg::CMD_RESET, 8'h00, 1'b0, LINE_RAND, 1'b0);
    settle();

    mark = items_sent;
    while (items_sent - mark < RANDOM_ITEMS) begin
      load_timing(pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks());
      repeat ($urandom_range(4, 10)) begin
        if (items_sent - mark < RANDOM_ITEMS) begin
          sel = $urandom_range(0, 19);
          if (sel < 5) c = owm_pkg::CMD_RESET;
          else if (sel < 11) c = owm_pkg::CMD_WRITE;
          else if (sel < 17) c = owm_pkg::CMD_READ;
          else c = owm_pkg::CMD_TICK;
          line = (c == owm_pkg::CMD_RESET) ? ($urandom_range(0, 6) != 0)
                                           : 1'($urandom_range(0, 1));
          run_op(c, 8'($urandom_range(0, 255)), line, $urandom_range(LINE_LOW, LINE_RAND),
                 1'($urandom_range(0, 1)));
        end
      end
      settle();
    end

    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* one_wire_master_sequencer.f */
+incdir+rtl
rtl/owm_pkg.sv
rtl/owm_front.sv
rtl/owm_queue.sv
rtl/owm_back.sv
rtl/one_wire_master_sequencer.sv
bench/one_wire_master_sequencer_checker.sv
bench/one_wire_master_sequencer_tb.sv
